// ===== src/dof_pkg.sv =====
// Shared types, codes and the control program for the DHCP option finder.
// Depends on nothing; every other file of the block refers to it by scoped names.
`timescale 1ns / 1ps

package dof_pkg;

  // Default region sizes in bytes.
  localparam int OPTIONS_BYTES_DEF = 308;
  localparam int FILE_BYTES_DEF    = 128;
  localparam int SNAME_BYTES_DEF   = 64;

  // Field widths fixed by the interface.
  localparam int CMD_W    = 1;
  localparam int REGION_W = 2;
  localparam int INDEX_W  = 9;
  localparam int BYTE_W   = 8;
  localparam int STATUS_W = 2;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 1'b0;
  localparam logic [CMD_W-1:0] CMD_SEARCH = 1'b1;

  // Region codes.
  localparam logic [REGION_W-1:0] REGION_OPTIONS = 2'd0;
  localparam logic [REGION_W-1:0] REGION_FILE    = 2'd1;
  localparam logic [REGION_W-1:0] REGION_SNAME   = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] ST_FOUND     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_BOGUS     = 2'd2;

  // Special option codes.
  localparam logic [BYTE_W-1:0] CODE_PAD      = 8'd0;
  localparam logic [BYTE_W-1:0] CODE_OVERLOAD = 8'd52;
  localparam logic [BYTE_W-1:0] CODE_END      = 8'd255;

  // Overload bit positions.
  localparam int OVL_FILE_BIT  = 0;
  localparam int OVL_SNAME_BIT = 1;

  // Datapath action selected by a control word.
  typedef enum logic [1:0] {
    ACT_IDLE,   // take loads and search requests
    ACT_FETCH,  // bound check, read code and length bytes
    ACT_EVAL,   // decode one entry
    ACT_OVL     // take the overload byte and skip the entry
  } act_t;

  // Jump condition of a control word.
  typedef enum logic [1:0] {
    COND_ALWAYS,
    COND_SEARCH,
    COND_OVL
  } cond_t;

  typedef logic [1:0] step_t;

  localparam step_t STEP_IDLE  = 2'd0;
  localparam step_t STEP_FETCH = 2'd1;
  localparam step_t STEP_EVAL  = 2'd2;
  localparam step_t STEP_OVL   = 2'd3;

  // One control word of the program.
  typedef struct packed {
    act_t  act;
    cond_t cond;
    step_t jump_to;
    step_t fall_to;
  } uword_t;

  // Status flags from the datapath to the sequencer.
  typedef struct packed {
    logic search_go;  // a search word was accepted
    logic ovl_go;     // the entry under decode is an overload entry
    logic done;       // a result is being issued
  } dp_flags_t;

  // Control program. A result from the datapath always returns to the idle step.
  function automatic uword_t ucode(input step_t step);
    uword_t w;
    unique case (step)
      STEP_IDLE:  w = '{act: ACT_IDLE,  cond: COND_SEARCH, jump_to: STEP_FETCH,
                        fall_to: STEP_IDLE};
      STEP_FETCH: w = '{act: ACT_FETCH, cond: COND_ALWAYS, jump_to: STEP_EVAL,
                        fall_to: STEP_EVAL};
      STEP_EVAL:  w = '{act: ACT_EVAL,  cond: COND_OVL,    jump_to: STEP_OVL,
                        fall_to: STEP_FETCH};
      STEP_OVL:   w = '{act: ACT_OVL,   cond: COND_ALWAYS, jump_to: STEP_FETCH,
                        fall_to: STEP_FETCH};
    endcase
    return w;
  endfunction

endpackage

// ===== src/dof_sequencer.sv =====
// Step counter and control program readout for the DHCP option finder.
// Depends on dof_pkg for the control word layout and the program itself.
`timescale 1ns / 1ps

module dof_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  dof_pkg::dp_flags_t flags,
  output dof_pkg::act_t     act,
  output logic              busy
);

  dof_pkg::step_t  step_r;
  dof_pkg::step_t  step_nxt;
  dof_pkg::uword_t uword;
  logic            cond_true;

  // Fetch the control word of the current step.
  assign uword = dof_pkg::ucode(step_r);
  assign act   = uword.act;
  assign busy  = (step_r != dof_pkg::STEP_IDLE);

  // Evaluate the jump condition.
  always_comb begin
    unique case (uword.cond)
      dof_pkg::COND_ALWAYS: cond_true = 1'b1;
      dof_pkg::COND_SEARCH: cond_true = flags.search_go;
      dof_pkg::COND_OVL:    cond_true = flags.ovl_go;
      default:              cond_true = 1'b0;
    endcase
  end

  // A finished search always goes back to the idle step.
  always_comb begin
    if (flags.done) begin
      step_nxt = dof_pkg::STEP_IDLE;
    end else if (cond_true) begin
      step_nxt = uword.jump_to;
    end else begin
      step_nxt = uword.fall_to;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= dof_pkg::STEP_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

// ===== src/dof_datapath.sv =====
// Message store and entry walk datapath of the DHCP option finder.
// Depends on dof_pkg for codes and types; driven by dof_sequencer.
`timescale 1ns / 1ps

module dof_datapath #(
  parameter int OPTIONS_BYTES = dof_pkg::OPTIONS_BYTES_DEF,
  parameter int FILE_BYTES    = dof_pkg::FILE_BYTES_DEF,
  parameter int SNAME_BYTES   = dof_pkg::SNAME_BYTES_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  dof_pkg::act_t                     act,
  input  logic                              start,
  input  logic [dof_pkg::CMD_W-1:0]         in_cmd,
  input  logic [dof_pkg::REGION_W-1:0]      in_region,
  input  logic [dof_pkg::INDEX_W-1:0]       in_byte_index,
  input  logic [dof_pkg::BYTE_W-1:0]        in_byte_value,
  input  logic [dof_pkg::BYTE_W-1:0]        in_option_code,
  output dof_pkg::dp_flags_t                flags,
  output logic                              out_valid,
  output logic [dof_pkg::STATUS_W-1:0]      out_status,
  output logic [dof_pkg::REGION_W-1:0]      out_found_region,
  output logic [dof_pkg::INDEX_W-1:0]       out_data_offset,
  output logic [dof_pkg::BYTE_W-1:0]        out_data_length
);

  localparam int STORE_BYTES = OPTIONS_BYTES + FILE_BYTES + SNAME_BYTES;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  // Wide enough for a position plus a length byte plus two.
  localparam int SUM_W       = $clog2(STORE_BYTES + 258);

  localparam logic [SUM_W-1:0] SIZE_OPT   = SUM_W'(OPTIONS_BYTES);
  localparam logic [SUM_W-1:0] SIZE_FILE  = SUM_W'(FILE_BYTES);
  localparam logic [SUM_W-1:0] SIZE_SNAME = SUM_W'(SNAME_BYTES);
  localparam logic [SUM_W-1:0] BASE_FILE  = SUM_W'(OPTIONS_BYTES);
  localparam logic [SUM_W-1:0] BASE_SNAME = SUM_W'(OPTIONS_BYTES + FILE_BYTES);

  logic [dof_pkg::BYTE_W-1:0] store [STORE_BYTES];

  // Walk state.
  logic [dof_pkg::REGION_W-1:0] cur_r, cur_nxt;
  logic [SUM_W-1:0]             pos_r, pos_nxt;
  logic [1:0]                   over_r, over_nxt;
  logic [dof_pkg::BYTE_W-1:0]   code_r, code_nxt;
  logic [dof_pkg::BYTE_W-1:0]   len_byte_r, len_byte_nxt;

  // Read ports: data and whether the address lay inside the region.
  logic [dof_pkg::BYTE_W-1:0]   rd_a_r, rd_b_r;
  logic                         ok_a_r, ok_a_nxt;
  logic                         ok_b_r, ok_b_nxt;
  logic [ADDR_W-1:0]            addr_a, addr_b;

  // Result registers.
  logic                         valid_r, valid_nxt;
  logic [dof_pkg::STATUS_W-1:0] status_r, status_nxt;
  logic [dof_pkg::REGION_W-1:0] freg_r, freg_nxt;
  logic [dof_pkg::INDEX_W-1:0]  foff_r, foff_nxt;
  logic [dof_pkg::BYTE_W-1:0]   flen_r, flen_nxt;

  logic [SUM_W-1:0]             reg_len, reg_base;
  logic [SUM_W-1:0]             ld_size, ld_base, ld_index;
  logic                         ld_en;
  logic [ADDR_W-1:0]            ld_addr;
  logic [dof_pkg::BYTE_W-1:0]   code_byte, len_byte;
  logic [SUM_W-1:0]             pos_p1, pos_p2, pos_skip, entry_last;
  logic                         overrun, in_range;

  // Size and base of the region under walk.
  always_comb begin
    unique case (cur_r)
      dof_pkg::REGION_FILE: begin
        reg_len  = SIZE_FILE;
        reg_base = BASE_FILE;
      end
      dof_pkg::REGION_SNAME: begin
        reg_len  = SIZE_SNAME;
        reg_base = BASE_SNAME;
      end
      default: begin
        reg_len  = SIZE_OPT;
        reg_base = '0;
      end
    endcase
  end

  // Load target decode; region three has no bytes.
  always_comb begin
    unique case (in_region)
      dof_pkg::REGION_OPTIONS: begin
        ld_size = SIZE_OPT;
        ld_base = '0;
      end
      dof_pkg::REGION_FILE: begin
        ld_size = SIZE_FILE;
        ld_base = BASE_FILE;
      end
      dof_pkg::REGION_SNAME: begin
        ld_size = SIZE_SNAME;
        ld_base = BASE_SNAME;
      end
      default: begin
        ld_size = '0;
        ld_base = '0;
      end
    endcase
  end

  assign ld_index = SUM_W'(in_byte_index);
  assign ld_en    = (act == dof_pkg::ACT_IDLE) && start && (in_cmd == dof_pkg::CMD_LOAD) &&
                    (ld_index < ld_size);
  assign ld_addr  = ADDR_W'(ld_base + ld_index);

  // Entry arithmetic; a length byte read past the region counts as zero.
  assign code_byte  = rd_a_r;
  assign len_byte   = ok_b_r ? rd_b_r : '0;
  assign pos_p1     = pos_r + SUM_W'(1);
  assign pos_p2     = pos_r + SUM_W'(2);
  assign pos_skip   = pos_p2 + SUM_W'(len_byte);
  assign entry_last = pos_p1 + SUM_W'(len_byte);
  assign overrun    = (entry_last >= reg_len);
  assign in_range   = (pos_r < reg_len);

  // Read addresses: port A takes the code byte or the overload byte,
  // port B the length byte. Out-of-region length and overload byte reads go to address zero.
  always_comb begin
    addr_a   = '0;
    addr_b   = '0;
    ok_a_nxt = 1'b0;
    ok_b_nxt = 1'b0;
    if (act == dof_pkg::ACT_FETCH) begin
      addr_a   = ADDR_W'(reg_base + pos_r);
      ok_a_nxt = 1'b1;
      ok_b_nxt = (pos_p1 < reg_len);
      if (ok_b_nxt) begin
        addr_b = ADDR_W'(reg_base + pos_p1);
      end
    end else if (act == dof_pkg::ACT_EVAL) begin
      ok_a_nxt = (pos_p2 < reg_len);
      if (ok_a_nxt) begin
        addr_a = ADDR_W'(reg_base + pos_p2);
      end
    end
  end

  // Byte store: one write port and two registered read ports.
  always_ff @(posedge clk) begin
    if (ld_en) begin
      store[ld_addr] <= in_byte_value;
    end
    rd_a_r <= store[addr_a];
    rd_b_r <= store[addr_b];
  end

  // Walk control and result formation.
  always_comb begin
    cur_nxt      = cur_r;
    pos_nxt      = pos_r;
    over_nxt     = over_r;
    code_nxt     = code_r;
    len_byte_nxt = len_byte_r;
    valid_nxt    = 1'b0;
    status_nxt   = status_r;
    freg_nxt     = freg_r;
    foff_nxt     = foff_r;
    flen_nxt     = flen_r;
    flags        = '0;

    unique case (act)
      dof_pkg::ACT_IDLE: begin
        if (start && (in_cmd == dof_pkg::CMD_SEARCH)) begin
          flags.search_go = 1'b1;
          cur_nxt         = dof_pkg::REGION_OPTIONS;
          pos_nxt         = '0;
          over_nxt        = '0;
          code_nxt        = in_option_code;
        end
      end

      dof_pkg::ACT_FETCH: begin
        if (!in_range) begin
          flags.done = 1'b1;
          valid_nxt  = 1'b1;
          status_nxt = dof_pkg::ST_BOGUS;
          freg_nxt   = '0;
          foff_nxt   = '0;
          flen_nxt   = '0;
        end
      end

      dof_pkg::ACT_EVAL: begin
        // The sought code is matched before any special code is handled.
        if (code_byte == code_r) begin
          flags.done = 1'b1;
          valid_nxt  = 1'b1;
          if (overrun) begin
            status_nxt = dof_pkg::ST_BOGUS;
            freg_nxt   = '0;
            foff_nxt   = '0;
            flen_nxt   = '0;
          end else begin
            status_nxt = dof_pkg::ST_FOUND;
            freg_nxt   = cur_r;
            foff_nxt   = dof_pkg::INDEX_W'(pos_p2);
            flen_nxt   = len_byte;
          end
        end else if (code_byte == dof_pkg::CODE_PAD) begin
          pos_nxt = pos_p1;
        end else if (code_byte == dof_pkg::CODE_OVERLOAD) begin
          if (overrun) begin
            flags.done = 1'b1;
            valid_nxt  = 1'b1;
            status_nxt = dof_pkg::ST_BOGUS;
            freg_nxt   = '0;
            foff_nxt   = '0;
            flen_nxt   = '0;
          end else begin
            flags.ovl_go = 1'b1;
            len_byte_nxt = len_byte;
          end
        end else if (code_byte == dof_pkg::CODE_END) begin
          if ((cur_r == dof_pkg::REGION_OPTIONS) && over_r[dof_pkg::OVL_FILE_BIT]) begin
            cur_nxt = dof_pkg::REGION_FILE;
            pos_nxt = '0;
          end else if ((cur_r == dof_pkg::REGION_FILE) &&
                       over_r[dof_pkg::OVL_SNAME_BIT]) begin
            cur_nxt = dof_pkg::REGION_SNAME;
            pos_nxt = '0;
          end else begin
            flags.done = 1'b1;
            valid_nxt  = 1'b1;
            status_nxt = dof_pkg::ST_NOT_FOUND;
            freg_nxt   = '0;
            foff_nxt   = '0;
            flen_nxt   = '0;
          end
        end else begin
          pos_nxt = pos_skip;
        end
      end

      dof_pkg::ACT_OVL: begin
        // Record the overload bits and skip the whole entry.
        over_nxt = ok_a_r ? rd_a_r[1:0] : 2'b00;
        pos_nxt  = pos_p2 + SUM_W'(len_byte_r);
      end

      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  // Walk and result payload registers need no reset.
  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    pos_r      <= pos_nxt;
    over_r     <= over_nxt;
    code_r     <= code_nxt;
    len_byte_r <= len_byte_nxt;
    ok_a_r     <= ok_a_nxt;
    ok_b_r     <= ok_b_nxt;
    status_r   <= status_nxt;
    freg_r     <= freg_nxt;
    foff_r     <= foff_nxt;
    flen_r     <= flen_nxt;
  end

  assign out_valid        = valid_r;
  assign out_status       = status_r;
  assign out_found_region = freg_r;
  assign out_data_offset  = foff_r;
  assign out_data_length  = flen_r;

endmodule

// ===== src/dhcp_option_finder.sv =====
// Top level of the DHCP option finder: sequencer plus store and walk datapath.
// Depends on dof_pkg, dof_sequencer and dof_datapath.
`timescale 1ns / 1ps

// A word is taken when start is high and busy is low. A load word writes one
// byte of the options, file or sname region; busy stays low. A search word
// walks the option entries under a small control program and returns one
// result on out_valid, a one-cycle strobe that the receiver must take. After
// the search word is taken, busy stays high while the walk runs. Each entry
// walked, pads and end codes included, takes a fetch step and an evaluate
// step (the code and length bytes come from the two read ports of the byte
// store in one step and are decoded in the next). Each overload entry adds
// an overload step for the third byte read. A walk that runs off the end of a
// region ends in a fetch step with a failed bound check. The result strobe
// comes in the cycle after the last of these steps, with busy already low.
// The next word can be taken in the strobe cycle.
// All three regions must be loaded before a search. The store has no reset and
// needs no clearing pass.
module dhcp_option_finder #(
  parameter int OPTIONS_BYTES = dof_pkg::OPTIONS_BYTES_DEF,
  parameter int FILE_BYTES    = dof_pkg::FILE_BYTES_DEF,
  parameter int SNAME_BYTES   = dof_pkg::SNAME_BYTES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [dof_pkg::CMD_W-1:0]    in_cmd,
  input  logic [dof_pkg::REGION_W-1:0] in_region,
  input  logic [dof_pkg::INDEX_W-1:0]  in_byte_index,
  input  logic [dof_pkg::BYTE_W-1:0]   in_byte_value,
  input  logic [dof_pkg::BYTE_W-1:0]   in_option_code,
  output logic                         out_valid,
  output logic [dof_pkg::STATUS_W-1:0] out_status,
  output logic [dof_pkg::REGION_W-1:0] out_found_region,
  output logic [dof_pkg::INDEX_W-1:0]  out_data_offset,
  output logic [dof_pkg::BYTE_W-1:0]   out_data_length
);

  dof_pkg::act_t      act;
  dof_pkg::dp_flags_t flags;

  // Control program and step counter.
  dof_sequencer u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .flags (flags),
    .act   (act),
    .busy  (busy)
  );

  // Byte store and entry walk.
  dof_datapath #(
    .OPTIONS_BYTES (OPTIONS_BYTES),
    .FILE_BYTES    (FILE_BYTES),
    .SNAME_BYTES   (SNAME_BYTES)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .act              (act),
    .start            (start),
    .in_cmd           (in_cmd),
    .in_region        (in_region),
    .in_byte_index    (in_byte_index),
    .in_byte_value    (in_byte_value),
    .in_option_code   (in_option_code),
    .flags            (flags),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_found_region (out_found_region),
    .out_data_offset  (out_data_offset),
    .out_data_length  (out_data_length)
  );

endmodule

// ===== src/dof_checker.sv =====
// Port-level checks for the DHCP option finder, bound to its top level.
// Depends on dof_pkg for the command and status codes.
`timescale 1ns / 1ps

module dof_checker (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [dof_pkg::CMD_W-1:0]    in_cmd,
  input logic                         out_valid,
  input logic [dof_pkg::STATUS_W-1:0] out_status,
  input logic [dof_pkg::REGION_W-1:0] out_found_region,
  input logic [dof_pkg::INDEX_W-1:0]  out_data_offset,
  input logic [dof_pkg::BYTE_W-1:0]   out_data_length
);

  // A result only ends a search that was running, and frees the block.
  a_result_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (!busy && $past(busy)))
    else $error("result without a running search");

  // The result strobe is never high twice in a row.
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  // A load word never makes the block busy.
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && (in_cmd == dof_pkg::CMD_LOAD)) |=> !busy)
    else $error("load word made the block busy");

  // Status is a defined code, and a miss carries no location.
  a_miss_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != dof_pkg::ST_FOUND)) |->
      ((out_status == dof_pkg::ST_NOT_FOUND || out_status == dof_pkg::ST_BOGUS) &&
       (out_found_region == '0) && (out_data_offset == '0) && (out_data_length == '0)))
    else $error("bad status or nonzero fields on a miss");

endmodule

bind dhcp_option_finder dof_checker u_dof_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .start            (start),
  .busy             (busy),
  .in_cmd           (in_cmd),
  .out_valid        (out_valid),
  .out_status       (out_status),
  .out_found_region (out_found_region),
  .out_data_offset  (out_data_offset),
  .out_data_length  (out_data_length)
);
